// ===== src/eid_pkg.sv =====
// Package with shared constants, kind codes and helpers for the Euclidean integer divider.
`default_nettype none

package eid_pkg;

    localparam int DATA_W = 64;
    localparam int CNT_W  = 6;

    localparam logic [CNT_W-1:0] TOP_NARROW = CNT_W'(31);
    localparam logic [CNT_W-1:0] TOP_WIDE   = CNT_W'(63);

    localparam logic [1:0] KIND_U32 = 2'd0;
    localparam logic [1:0] KIND_S32 = 2'd1;
    localparam logic [1:0] KIND_U64 = 2'd2;
    localparam logic [1:0] KIND_S64 = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] diff;
        logic              ge;
    } t_sub_res;

    function automatic logic [DATA_W-1:0] width_mask(input logic wide);
        return wide ? {DATA_W{1'b1}} : {{(DATA_W/2){1'b0}}, {(DATA_W/2){1'b1}}};
    endfunction

endpackage

`default_nettype wire

// ===== src/eid_sub.sv =====
// Shared subtractor of the divider: one operand-plus-one-bit subtract with a no-borrow flag.
`default_nettype none

module eid_sub (
    input  wire logic [eid_pkg::DATA_W:0]   i_a,
    input  wire logic [eid_pkg::DATA_W:0]   i_b,
    output eid_pkg::t_sub_res               o_res
);

    logic [eid_pkg::DATA_W+1:0] w_full;

    assign w_full     = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.diff = w_full[eid_pkg::DATA_W-1:0];
    assign o_res.ge   = ~w_full[eid_pkg::DATA_W+1];

endmodule

`default_nettype wire

// ===== src/euclidean_integer_divider.sv =====
// Top level of the Euclidean integer divider: sequencer, operand registers and output register.
`default_nettype none

// One transaction in, one out. Unsigned kinds run the restoring loop alone; signed kinds first
// negate negative operands and after the loop do the Euclidean fix-up, and a zero divisor goes
// straight to the done state. The sequencer returns to idle on the edge that loads the output
// register, so a new transaction is accepted only once the last one has left the sequencer. The
// restoring loop retires one quotient bit per cycle through a single shared subtractor that also
// does the sign negations and the Euclidean fix-up. The input is ready whenever the sequencer is
// idle, even while a finished result waits in the output register; a finished result waits in the
// sequencer while the output register is still held by a stalled result.
module euclidean_integer_divider (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // Fields from bit 0: dividend[63:0], divisor[127:64].
    input  wire logic [127:0]   i_s_axis_tdata,
    // Fields from bit 0: kind[1:0].
    input  wire logic [1:0]     i_s_axis_tuser,
    output logic                o_m_axis_tvalid,
    input  wire logic           i_m_axis_tready,
    // Fields from bit 0: quotient[63:0], remainder[127:64].
    output logic [127:0]        o_m_axis_tdata,
    // Fields from bit 0: divide_by_zero[0].
    output logic [0:0]          o_m_axis_tuser
);

    localparam int W = eid_pkg::DATA_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEG_N,
        ST_NEG_D,
        ST_DIV,
        ST_FIX_R,
        ST_FIX_Q,
        ST_DONE
    } t_state;

    t_state                     r_state;
    logic                       r_wide;
    logic                       r_signed;
    logic                       r_n_neg;
    logic                       r_d_neg;
    logic                       r_neg_q;
    logic                       r_dz;
    logic [W-1:0]               r_n;
    logic [W-1:0]               r_d;
    logic [W-1:0]               r_rem;
    logic [W-1:0]               r_quo;
    logic [eid_pkg::CNT_W-1:0]  r_cnt;
    logic [W-1:0]               r_out_quo;
    logic [W-1:0]               r_out_rem;
    logic                       r_out_dz;
    logic                       r_out_valid;

    logic [W:0]                 w_a;
    logic [W:0]                 w_b;
    eid_pkg::t_sub_res          w_sub;
    logic                       w_accept;
    logic                       w_in_wide;
    logic [W-1:0]               w_in_mask;
    logic [W-1:0]               w_in_n;
    logic [W-1:0]               w_in_d;
    logic [W-1:0]               w_mask;
    logic                       w_n_bit;

    assign w_in_wide = (i_s_axis_tuser == eid_pkg::KIND_U64) ||
                       (i_s_axis_tuser == eid_pkg::KIND_S64);
    assign w_in_mask = eid_pkg::width_mask(w_in_wide);
    assign w_in_n    = i_s_axis_tdata[W-1:0] & w_in_mask;
    assign w_in_d    = i_s_axis_tdata[2*W-1:W] & w_in_mask;
    assign w_mask    = eid_pkg::width_mask(r_wide);
    assign w_n_bit   = r_wide ? r_n[W-1] : r_n[W/2-1];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        unique case (r_state)
            ST_NEG_N: begin
                w_a = '0;
                w_b = {1'b0, r_n};
            end
            ST_NEG_D: begin
                w_a = '0;
                w_b = {1'b0, r_d};
            end
            ST_DIV: begin
                w_a = {r_rem, w_n_bit};
                w_b = {1'b0, r_d};
            end
            ST_FIX_R: begin
                w_a = {1'b0, r_d};
                w_b = {1'b0, r_rem};
            end
            ST_FIX_Q: begin
                w_a = '0;
                w_b = {1'b0, r_quo};
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    eid_sub u_sub (
        .i_a   (w_a),
        .i_b   (w_b),
        .o_res (w_sub)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_wide   <= w_in_wide;
                        r_signed <= (i_s_axis_tuser == eid_pkg::KIND_S32) ||
                                    (i_s_axis_tuser == eid_pkg::KIND_S64);
                        r_n      <= w_in_n;
                        r_d      <= w_in_d;
                        r_n_neg  <= w_in_wide ? w_in_n[W-1] : w_in_n[W/2-1];
                        r_d_neg  <= w_in_wide ? w_in_d[W-1] : w_in_d[W/2-1];
                        r_rem    <= '0;
                        r_quo    <= '0;
                        r_neg_q  <= 1'b0;
                        r_cnt    <= w_in_wide ? eid_pkg::TOP_WIDE : eid_pkg::TOP_NARROW;
                        r_dz     <= (w_in_d == '0);
                        if (w_in_d == '0) begin
                            r_state <= ST_DONE;
                        end else if ((i_s_axis_tuser == eid_pkg::KIND_S32) ||
                                     (i_s_axis_tuser == eid_pkg::KIND_S64)) begin
                            r_state <= ST_NEG_N;
                        end else begin
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_NEG_N: begin
                    if (r_n_neg) begin
                        r_n <= w_sub.diff & w_mask;
                    end
                    r_state <= ST_NEG_D;
                end
                ST_NEG_D: begin
                    if (r_d_neg) begin
                        r_d <= w_sub.diff & w_mask;
                    end
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_n   <= {r_n[W-2:0], 1'b0};
                    r_rem <= w_sub.ge ? w_sub.diff : w_a[W-1:0];
                    r_quo <= {r_quo[W-2:0], w_sub.ge};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= r_signed ? ST_FIX_R : ST_DONE;
                    end
                end
                ST_FIX_R: begin
                    if (r_n_neg && (r_rem != '0)) begin
                        r_rem <= w_sub.diff & w_mask;
                        r_quo <= ~r_quo;
                    end
                    r_neg_q <= (r_n_neg && (r_rem == '0)) ^ r_d_neg;
                    r_state <= ST_FIX_Q;
                end
                ST_FIX_Q: begin
                    if (r_neg_q) begin
                        r_quo <= w_sub.diff;
                    end
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_dz    <= r_dz;
                        r_out_quo   <= r_dz ? '0 : (r_quo & w_mask);
                        r_out_rem   <= r_dz ? '0 : (r_rem & w_mask);
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_rem, r_out_quo};
    assign o_m_axis_tuser  = r_out_dz;

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("Divide-by-zero result carries nonzero data.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("Input ready right after a transaction was accepted.");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_d))
        else $error("Partial remainder reached the divisor.");

    a_cnt_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV) && $past(r_state == ST_DIV)) |->
        (r_cnt == $past(r_cnt) - 1'b1))
        else $error("Bit counter did not step down during division.");

    a_no_done_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !i_m_axis_tready) |=>
        (r_state == ST_DONE))
        else $error("Result left the sequencer while the output was stalled.");

endmodule

`default_nettype wire
